// File: hdl/egncd_pkg.sv
`default_nettype none
package egncd_pkg;

    localparam int NUM_CARS_DEF   = 4;
    localparam int NUM_FLOORS_DEF = 32;

    localparam int CFG_CARS  = 4;
    localparam int CAR_W     = 2;
    localparam int FLOOR_W   = 5;
    localparam int WEIGHT_W  = 10;
    localparam int CAP_W     = 6;
    localparam int LIM_W     = 12;
    localparam int PASS_W    = 6;
    localparam int LOAD_W    = 12;

    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_CAP0 = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LIM0 = 3'd4;

    localparam logic [CAP_W-1:0] CAP_RST = 6'd8;
    localparam logic [LIM_W-1:0] LIM_RST = 12'd600;

    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 3;
    localparam int OUT_TDATA_W = 32;

    typedef enum logic [2:0] {
        OP_HALL    = 3'd0,
        OP_SELECT  = 3'd1,
        OP_MOVE    = 3'd2,
        OP_ENTER   = 3'd3,
        OP_EXIT    = 3'd4,
        OP_EMERG   = 3'd5,
        OP_CLR_EMG = 3'd6,
        OP_MAINT   = 3'd7
    } t_op;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_MOVING = 2'd1,
        MODE_MAINT  = 2'd2,
        MODE_EMERG  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        HEAD_UP   = 2'd0,
        HEAD_DOWN = 2'd1,
        HEAD_IDLE = 2'd2
    } t_head;

    typedef struct packed {
        logic [CFG_CARS-1:0][CAP_W-1:0] cap;
        logic [CFG_CARS-1:0][LIM_W-1:0] lim;
    } t_cfg;

    typedef struct packed {
        t_op                 op;
        logic [CAR_W-1:0]    car;
        logic [FLOOR_W-1:0]  floor;
        logic [WEIGHT_W-1:0] weight;
        logic                mon;
    } t_item;

    typedef struct packed {
        logic [CAR_W-1:0]   chosen;
        logic               ok;
        logic [FLOOR_W-1:0] floor_now;
        t_head              head;
        t_mode              mode;
        logic               arrived;
        logic               over;
        logic [PASS_W-1:0]  pass;
        logic [LOAD_W-1:0]  load;
    } t_res;

    typedef struct packed {
        logic             found;
        logic [CAR_W-1:0] car;
    } t_pick;

endpackage
`default_nettype wire

// File: hdl/elevator_group_nearest_car_dispatch_top.sv
// A request is held in the input register and its result in the result register.
// Throughput: one request per cycle while the output is not stalled; the input
// register, the per-car update logic and the result register make a single pass.
// Reset: synchronous, active low; all cars go idle at the ground floor with
// no pending floors, capacities return to 8 and weight limits to 600 kg.
`default_nettype none
module elevator_group_nearest_car_dispatch_top
    import egncd_pkg::*;
#(
    parameter int NUM_CARS   = NUM_CARS_DEF,
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // car[1:0], floor[6:2], weight[16:7], maintenance_on[17], zero pad
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // op[2:0]
    input  wire logic [IN_TUSER_W-1:0]  s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // chosen_car[1:0], ok[2], car_floor_now[7:3], heading[9:8], mode[11:10],
    // arrived[12], overloaded[13], passengers_now[19:14], load_now[31:20]
    output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [PADDR_W-1:0]     paddr,
    input  wire logic [PDATA_W-1:0]     pwdata,
    output logic      [PDATA_W-1:0]     prdata,
    output logic                        pready
);

    logic  r_in_vld;
    t_item r_item;
    logic  r_out_vld;
    t_res  r_res;
    t_res  res;
    t_cfg  cfg;
    logic  adv;

    egncd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    egncd_core #(
        .NUM_CARS   (NUM_CARS),
        .NUM_FLOORS (NUM_FLOORS)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_item.op     <= t_op'(s_axis_tuser[2:0]);
            r_item.car    <= s_axis_tdata[1:0];
            r_item.floor  <= s_axis_tdata[6:2];
            r_item.weight <= s_axis_tdata[16:7];
            r_item.mon    <= s_axis_tdata[17];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_res.load, r_res.pass, r_res.over, r_res.arrived,
                            r_res.mode, r_res.head, r_res.floor_now, r_res.ok,
                            r_res.chosen};

endmodule
`default_nettype wire

// File: hdl/egncd_cfg.sv
`default_nettype none
module egncd_cfg
    import egncd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output t_cfg                    o_cfg
);

    logic [CFG_CARS-1:0][CAP_W-1:0] r_cap;
    logic [CFG_CARS-1:0][LIM_W-1:0] r_lim;
    logic [REG_IDX_W-1:0]           idx;
    logic [CAR_W-1:0]               sub;
    logic                           wr;

    assign idx    = paddr[PADDR_W-1:2];
    assign sub    = idx[CAR_W-1:0];
    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CFG_CARS; i++) begin
                r_cap[i] <= CAP_RST;
                r_lim[i] <= LIM_RST;
            end
        end else if (wr) begin
            if (idx < REG_LIM0) begin
                r_cap[sub] <= pwdata[CAP_W-1:0];
            end else begin
                r_lim[sub] <= pwdata[LIM_W-1:0];
            end
        end
    end

    always_comb begin
        if (idx < REG_LIM0) begin
            prdata = PDATA_W'(r_cap[sub]);
        end else begin
            prdata = PDATA_W'(r_lim[sub]);
        end
    end

    assign o_cfg.cap = r_cap;
    assign o_cfg.lim = r_lim;

endmodule
`default_nettype wire

// File: hdl/egncd_pick.sv
`default_nettype none
module egncd_pick
    import egncd_pkg::*;
#(
    parameter int NUM_CARS = NUM_CARS_DEF
) (
    input  wire logic  [NUM_CARS-1:0][FLOOR_W-1:0] i_pos,
    input  wire t_mode [NUM_CARS-1:0]              i_mode,
    input  wire logic  [FLOOR_W-1:0]               i_floor,
    output t_pick                                  o_pick
);

    logic [FLOOR_W-1:0] d;
    logic [FLOOR_W-1:0] bestd;
    logic               found;
    logic [CAR_W-1:0]   best;

    // nearest available car, lowest index wins ties
    always_comb begin
        found = 1'b0;
        best  = '0;
        bestd = '0;
        d     = '0;
        for (int i = 0; i < NUM_CARS; i++) begin
            d = (i_pos[i] > i_floor) ? i_pos[i] - i_floor : i_floor - i_pos[i];
            if (i_mode[i] != MODE_MAINT && i_mode[i] != MODE_EMERG) begin
                if (!found || d < bestd) begin
                    found = 1'b1;
                    bestd = d;
                    best  = CAR_W'(i);
                end
            end
        end
        o_pick.found = found;
        o_pick.car   = best;
    end

endmodule
`default_nettype wire

// File: hdl/egncd_core.sv
`default_nettype none
module egncd_core
    import egncd_pkg::*;
#(
    parameter int NUM_CARS   = NUM_CARS_DEF,
    parameter int NUM_FLOORS = NUM_FLOORS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_res       o_res
);

    localparam int FW = $clog2(NUM_FLOORS);
    localparam int CW = (FW > FLOOR_W) ? FW : FLOOR_W;

    logic  [NUM_CARS-1:0][FLOOR_W-1:0]    r_pos;
    logic  [NUM_CARS-1:0][NUM_FLOORS-1:0] r_pend;
    t_mode [NUM_CARS-1:0]                 r_mode;
    t_head [NUM_CARS-1:0]                 r_head;
    logic  [NUM_CARS-1:0][PASS_W-1:0]     r_pass;
    logic  [NUM_CARS-1:0][LOAD_W-1:0]     r_load;

    logic [FLOOR_W-1:0]    n_pos;
    logic [NUM_FLOORS-1:0] n_pend;
    t_mode                 n_mode;
    t_head                 n_head;
    logic [PASS_W-1:0]     n_pass;
    logic [LOAD_W-1:0]     n_load;

    logic [FLOOR_W-1:0]    c_pos;
    logic [NUM_FLOORS-1:0] c_pend;
    t_mode                 c_mode;
    t_head                 c_head;
    logic [PASS_W-1:0]     c_pass;
    logic [LOAD_W-1:0]     c_load;
    logic [CAP_W-1:0]      c_cap;
    logic [LIM_W-1:0]      c_lim;

    t_pick                 pick;
    logic                  floor_ok;
    logic                  is_hall;
    logic                  car_ok;
    logic [CAR_W-1:0]      sel;
    logic [NUM_FLOORS-1:0] fbit;
    logic                  avail;
    logic [FW-1:0]         tgt;
    logic [NUM_FLOORS-1:0] tbit;
    logic                  ok;
    logic                  arrived;
    logic                  over;

    egncd_pick #(
        .NUM_CARS (NUM_CARS)
    ) u_pick (
        .i_pos   (r_pos),
        .i_mode  (r_mode),
        .i_floor (i_item.floor),
        .o_pick  (pick)
    );

    // select the addressed or chosen car
    always_comb begin
        floor_ok = 32'(i_item.floor) < NUM_FLOORS;
        fbit     = floor_ok ? (NUM_FLOORS'(1) << i_item.floor) : '0;
        is_hall  = (i_item.op == OP_HALL);
        sel      = is_hall ? pick.car : i_item.car;
        car_ok   = is_hall ? (floor_ok && pick.found) : (32'(i_item.car) < NUM_CARS);
        c_pos  = '0;
        c_pend = '0;
        c_mode = MODE_IDLE;
        c_head = HEAD_IDLE;
        c_pass = '0;
        c_load = '0;
        c_cap  = '0;
        c_lim  = '0;
        for (int i = 0; i < NUM_CARS; i++) begin
            if (sel == CAR_W'(i)) begin
                c_pos  = r_pos[i];
                c_pend = r_pend[i];
                c_mode = r_mode[i];
                c_head = r_head[i];
                c_pass = r_pass[i];
                c_load = r_load[i];
                c_cap  = i_cfg.cap[i];
                c_lim  = i_cfg.lim[i];
            end
        end
    end

    // lowest pending floor
    always_comb begin
        tgt = '0;
        for (int j = NUM_FLOORS - 1; j >= 0; j--) begin
            if (c_pend[j]) begin
                tgt = FW'(j);
            end
        end
        tbit = NUM_FLOORS'(1) << tgt;
    end

    always_comb begin
        avail   = (c_mode != MODE_MAINT) && (c_mode != MODE_EMERG);
        n_pos   = c_pos;
        n_pend  = c_pend;
        n_mode  = c_mode;
        n_head  = c_head;
        n_pass  = c_pass;
        n_load  = c_load;
        ok      = 1'b0;
        arrived = 1'b0;
        over    = 1'b0;
        unique case (i_item.op)
            OP_HALL: begin
                n_pend = c_pend | fbit;
                ok     = 1'b1;
            end
            OP_SELECT: begin
                if (floor_ok && avail) begin
                    n_pend = c_pend | fbit;
                    ok     = 1'b1;
                end
            end
            OP_MOVE: begin
                if (avail) begin
                    if (c_pass > c_cap || c_load > c_lim) begin
                        over = 1'b1;
                    end else if (c_pend == '0) begin
                        n_head = HEAD_IDLE;
                        n_mode = MODE_IDLE;
                    end else begin
                        n_mode = MODE_MOVING;
                        if (CW'(c_pos) < CW'(tgt)) begin
                            n_pos  = c_pos + 1'b1;
                            n_head = HEAD_UP;
                        end else if (CW'(c_pos) > CW'(tgt)) begin
                            n_pos  = c_pos - 1'b1;
                            n_head = HEAD_DOWN;
                        end
                        if (CW'(n_pos) == CW'(tgt)) begin
                            n_pend  = c_pend & ~tbit;
                            n_head  = HEAD_IDLE;
                            n_mode  = MODE_IDLE;
                            arrived = 1'b1;
                        end
                    end
                end
            end
            OP_ENTER: begin
                if ({1'b0, c_pass} + 1'b1 <= {1'b0, c_cap} &&
                    {1'b0, c_load} + LOAD_W'(i_item.weight) <= {1'b0, c_lim}) begin
                    n_pass = c_pass + 1'b1;
                    n_load = c_load + LOAD_W'(i_item.weight);
                    ok     = 1'b1;
                end
            end
            OP_EXIT: begin
                if (c_pass != '0) begin
                    n_pass = c_pass - 1'b1;
                end
                n_load = (c_load > LOAD_W'(i_item.weight)) ?
                         c_load - LOAD_W'(i_item.weight) : '0;
            end
            OP_EMERG: begin
                n_mode = MODE_EMERG;
                n_head = HEAD_IDLE;
            end
            OP_CLR_EMG: begin
                if (c_mode == MODE_EMERG) begin
                    n_mode = MODE_IDLE;
                end
            end
            OP_MAINT: begin
                if (i_item.mon) begin
                    n_mode = MODE_MAINT;
                    n_head = HEAD_IDLE;
                end else begin
                    n_mode = MODE_IDLE;
                end
            end
            default: begin
                n_mode = c_mode;
            end
        endcase
    end

    always_comb begin
        o_res.chosen = sel;
        if (car_ok) begin
            o_res.ok        = ok;
            o_res.floor_now = n_pos;
            o_res.head      = n_head;
            o_res.mode      = n_mode;
            o_res.arrived   = arrived;
            o_res.over      = over;
            o_res.pass      = n_pass;
            o_res.load      = n_load;
        end else begin
            o_res.chosen    = is_hall ? '0 : i_item.car;
            o_res.ok        = 1'b0;
            o_res.floor_now = '0;
            o_res.head      = HEAD_IDLE;
            o_res.mode      = MODE_IDLE;
            o_res.arrived   = 1'b0;
            o_res.over      = 1'b0;
            o_res.pass      = '0;
            o_res.load      = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CARS; i++) begin
                r_pos[i]  <= '0;
                r_pend[i] <= '0;
                r_mode[i] <= MODE_IDLE;
                r_head[i] <= HEAD_IDLE;
                r_pass[i] <= '0;
                r_load[i] <= '0;
            end
        end else if (i_en && car_ok) begin
            for (int i = 0; i < NUM_CARS; i++) begin
                if (sel == CAR_W'(i)) begin
                    r_pos[i]  <= n_pos;
                    r_pend[i] <= n_pend;
                    r_mode[i] <= n_mode;
                    r_head[i] <= n_head;
                    r_pass[i] <= n_pass;
                    r_load[i] <= n_load;
                end
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/egncd_chk.sv
`default_nettype none
module egncd_chk
    import egncd_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[13] |-> !m_axis_tdata[12] && !m_axis_tdata[2])
        else $error("overloaded move also arrived or reported ok");

    a_arr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[12] |->
            m_axis_tdata[9:8] == HEAD_IDLE && m_axis_tdata[11:10] == MODE_IDLE)
        else $error("arrived car not idle");

endmodule

bind elevator_group_nearest_car_dispatch_top egncd_chk u_chk (.*);
`default_nettype wire
